// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types, constants and helpers of the mandelbrot escape-time unit
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int PIXEL_W     = 10;
   localparam int COORD_W     = 32;
   localparam int STEP_W      = 31;
   localparam int PROD_W      = PIXEL_W + STEP_W;
   localparam int COUNT_W     = 16;
   localparam int CLASS_W     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // reset values of the configuration registers
   localparam logic [COORD_W-1:0] ORIGIN_X_RESET = 32'hE000_0000;
   localparam logic [COORD_W-1:0] ORIGIN_Y_RESET = 32'hE800_0000;
   localparam logic [STEP_W-1:0]  STEP_X_RESET   = 31'd1238631;
   localparam logic [STEP_W-1:0]  STEP_Y_RESET   = 31'd1238631;
   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;

   // limit / 3 as (limit * 43691) >> 17, exact for 16-bit limits
   localparam logic [COUNT_W-1:0] THIRD_RECIP = 16'd43691;
   localparam int                 THIRD_SHIFT = 17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_STEP_X   = 3'd2,
      CSR_STEP_Y   = 3'd3,
      CSR_MAX_ITER = 3'd4
   } csr_index_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_BLACK = 2'd0,
      CLASS_WHITE = 2'd1,
      CLASS_GREEN = 2'd2,
      CLASS_BLUE  = 2'd3
   } color_class_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_ADD,
      BACK_DONE
   } back_state_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_col;
      logic [PIXEL_W-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] escape_count;
      logic [CLASS_W-1:0] color_class;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } point_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [COORD_W-1:0] r;
      if (v[63:31] == {33{v[63]}}) begin
         r = v[31:0];
      end else if (v[63]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// ===== design/mbe_front.sv =====
// ----------------------------------------------------------------------------
// mbe_front
// accepts pixels and maps them to points c = origin + pixel * step
// ----------------------------------------------------------------------------
module mbe_front
   import mbe_pkg::*;
#(
   parameter int PIXEL_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   input  logic signed [COORD_W-1:0] origin_x,
   input  logic signed [COORD_W-1:0] origin_y,
   input  logic [STEP_W-1:0]         step_x,
   input  logic [STEP_W-1:0]         step_y,
   input  queue_status_type          q_status,
   output logic                      q_push,
   output point_type                 q_point
);

   localparam int USE_BITS = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
   localparam logic [PIXEL_W-1:0] PIX_MASK = PIXEL_W'((64'd1 << USE_BITS) - 64'd1);

   logic              p_valid_ff, p_valid_in;
   logic [PROD_W-1:0] prod_x_ff, prod_x_in;
   logic [PROD_W-1:0] prod_y_ff, prod_y_in;
   logic [PIXEL_W-1:0] col, row;
   logic              accept;
   logic signed [63:0] sum_x, sum_y;

   assign col       = req_data.pixel_col & PIX_MASK;
   assign row       = req_data.pixel_row & PIX_MASK;
   assign req_stall = p_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = p_valid_ff && !q_status.full;

   always_comb begin
      p_valid_in = accept || (p_valid_ff && q_status.full);
      prod_x_in  = prod_x_ff;
      prod_y_in  = prod_y_ff;
      if (accept) begin
         prod_x_in = PROD_W'(col) * PROD_W'(step_x);
         prod_y_in = PROD_W'(row) * PROD_W'(step_y);
      end
   end

   // exact sum, then clamp
   assign sum_x = $signed({{32{origin_x[COORD_W-1]}}, origin_x})
                + $signed({{(64-PROD_W){1'b0}}, prod_x_ff});
   assign sum_y = $signed({{32{origin_y[COORD_W-1]}}, origin_y})
                + $signed({{(64-PROD_W){1'b0}}, prod_y_ff});
   assign q_point.cx = sat32(sum_x);
   assign q_point.cy = sat32(sum_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
   end

endmodule

// ===== design/mbe_queue.sv =====
// ----------------------------------------------------------------------------
// mbe_queue
// short point queue between the front and the iteration engine
// ----------------------------------------------------------------------------
module mbe_queue
   import mbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  point_type        push_data,
   input  logic             pop,
   output point_type        pop_data,
   output queue_status_type status
);

   point_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign status.full  = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mbe_back.sv =====
// ----------------------------------------------------------------------------
// mbe_back
// iteration engine: z = z^2 + c, escape count, color class, result register
// ----------------------------------------------------------------------------
module mbe_back
   import mbe_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  queue_status_type   q_status,
   input  point_type          q_point,
   output logic               q_pop,
   input  logic [COUNT_W-1:0] max_iterations,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   localparam logic signed [63:0] FOUR = 64'sd4 <<< FRAC_BITS;

   back_state_type state_ff, state_in;

   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [63:0]        xx_ff, xx_in, yy_ff, yy_in, xy_ff, xy_in;
   logic [COUNT_W-1:0]        count_ff, count_in, limit_ff, limit_in;
   logic [COUNT_W-1:0]        third_ff, third_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic signed [63:0]        x2, y2, xy_sh, mag, nx, ny;
   logic [COUNT_W-1:0]        count_inc;
   logic [2*COUNT_W-1:0]      third_prod;
   logic [CLASS_W-1:0]        cls;

   assign x2        = xx_ff >>> FRAC_BITS;
   assign y2        = yy_ff >>> FRAC_BITS;
   assign xy_sh     = xy_ff >>> (FRAC_BITS - 1);
   assign mag       = x2 + y2;
   assign nx        = x2 - y2 + 64'(cx_ff);
   assign ny        = xy_sh + 64'(cy_ff);
   assign count_inc = count_ff + 1'b1;
   assign third_prod = (2*COUNT_W)'(max_iterations) * (2*COUNT_W)'(THIRD_RECIP);

   always_comb begin
      if (count_ff == limit_ff) begin
         cls = CLASS_BLACK;
      end else if (count_ff < third_ff) begin
         cls = CLASS_WHITE;
      end else if ({1'b0, count_ff} < {third_ff, 1'b0}) begin
         cls = CLASS_GREEN;
      end else begin
         cls = CLASS_BLUE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      xy_in        = xy_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      third_in     = third_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cx_in    = q_point.cx;
               cy_in    = q_point.cy;
               x_in     = '0;
               y_in     = '0;
               count_in = '0;
               limit_in = max_iterations;
               third_in = COUNT_W'(third_prod >> THIRD_SHIFT);
               state_in = (max_iterations == '0) ? BACK_DONE : BACK_MUL;
            end
         end
         BACK_MUL: begin
            xx_in    = x_ff * x_ff;
            yy_in    = y_ff * y_ff;
            xy_in    = x_ff * y_ff;
            state_in = BACK_ADD;
         end
         BACK_ADD: begin
            if (mag > FOUR) begin
               state_in = BACK_DONE;
            end else begin
               count_in = count_inc;
               x_in     = sat32(nx);
               y_in     = sat32(ny);
               state_in = (count_inc == limit_ff) ? BACK_DONE : BACK_MUL;
            end
         end
         BACK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.escape_count = count_ff;
               rsp_data_in.color_class  = cls;
               state_in                 = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      xy_ff       <= xy_in;
      count_ff    <= count_in;
      limit_ff    <= limit_in;
      third_ff    <= third_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/mandelbrot_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// a pixel goes through the front product register into the point queue; the
// iteration engine then pops it and runs n iterations (n <= max_iterations)
// in the single shared multiply / update loop, a multiply state then an update
// state per iteration, and takes the next pixel after registering the result
// reset: synchronous, clears queue, engine and handshakes; csr regs to defaults
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top
   import mbe_pkg::*;
#(
   parameter int PIXEL_BITS = 10,
   parameter int FRAC_BITS  = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers; written by the user only while idle, not enforced
   logic signed [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_W-1:0] origin_y_ff, origin_y_in;
   logic [STEP_W-1:0]         step_x_ff, step_x_in;
   logic [STEP_W-1:0]         step_y_ff, step_y_in;
   logic [COUNT_W-1:0]        max_iter_ff, max_iter_in;

   // front to queue to back
   queue_status_type q_status;
   logic             q_push, q_pop;
   point_type        push_point, pop_point;
   logic             csr_write;

   // register port never back-pressures
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // index decode; unused indexes drop the transfer
   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      max_iter_in = max_iter_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_in = csr_data;
            CSR_ORIGIN_Y: origin_y_in = csr_data;
            CSR_STEP_X:   step_x_in   = csr_data[STEP_W-1:0];
            CSR_STEP_Y:   step_y_in   = csr_data[STEP_W-1:0];
            CSR_MAX_ITER: max_iter_in = csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= ORIGIN_X_RESET;
         origin_y_ff <= ORIGIN_Y_RESET;
         step_x_ff   <= STEP_X_RESET;
         step_y_ff   <= STEP_Y_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         max_iter_ff <= max_iter_in;
      end
   end

   // front: pixel transfer, multiply by step, add origin and clamp
   mbe_front #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .step_x    (step_x_ff),
      .step_y    (step_y_ff),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_point   (push_point)
   );

   // decouples pixel intake from the long iteration runs
   mbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_point),
      .pop       (q_pop),
      .pop_data  (pop_point),
      .status    (q_status)
   );

   // back: escape-time loop plus result register
   mbe_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_point        (pop_point),
      .q_pop          (q_pop),
      .max_iterations (max_iter_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

   // count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.escape_count <= max_iter_ff))
      else $error("escape count above limit");

   // black exactly when the limit was reached
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.color_class == CLASS_BLACK) ==
                     (rsp_data.escape_count == max_iter_ff)))
      else $error("color class disagrees with count");

   // queue flags are exclusive
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   // front only stalls while a point waits on a full queue
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_status.full)
      else $error("front stalled with queue space");

endmodule

// ===== test/mandelbrot_escape_time_top_tb.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top_tb
// self-checking bench for the escape-time pixel unit: a local fixed-point
// predictor computes count and color class per pixel, results are compared
// in order, with random idling on both channels and one long result hold-off
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top_tb
   import mbe_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_Q     = 28;
   localparam int PIXEL_MAX  = (1 << PIXEL_W) - 1;
   localparam int DRAIN_PAD  = 16;    // settle time past the last checked result
   localparam int PRESSURE_HOLD = 400;
   localparam int WINDOW_COUNT  = 8;
   localparam int WINDOW_ITEMS  = 85;

   localparam longint COORD_MAX = (longint'(1) <<< 31) - 1;
   localparam longint COORD_MIN = -(longint'(1) <<< 31);
   localparam longint ESCAPE_RADIUS_SQ = longint'(4) <<< FRAC_Q;

   // q4.28 constants used by the directed cases
   localparam logic [COORD_W-1:0] Q_ZERO      = '0;
   localparam logic [COORD_W-1:0] Q_MINUS_TWO = 32'hE000_0000;
   localparam logic [COORD_W-1:0] Q_TWO       = 32'h2000_0000;
   localparam logic [COORD_W-1:0] Q_ONE       = 32'h1000_0000;
   localparam logic [COORD_W-1:0] Q_QUARTER   = 32'h0400_0000;
   localparam logic [COORD_W-1:0] Q_MOST_POS  = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] Q_MOST_NEG  = 32'h8000_0000;
   localparam logic [COUNT_W-1:0] LIMIT_DEEP  = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = CSR_INDEX_W'(CSR_MAX_ITER + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LAST  = '1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // predictor copy of the register file
   logic signed [COORD_W-1:0] cfg_origin_x = ORIGIN_X_RESET;
   logic signed [COORD_W-1:0] cfg_origin_y = ORIGIN_Y_RESET;
   logic [STEP_W-1:0]         cfg_step_x   = STEP_X_RESET;
   logic [STEP_W-1:0]         cfg_step_y   = STEP_Y_RESET;
   logic [COUNT_W-1:0]        cfg_limit    = MAX_ITER_RESET;

   rsp_type pending_escapes[$];

   int unsigned tx_max_gap = 0;
   int unsigned rsp_max_gap = 0;
   int unsigned rsp_hold = 0;
   int pressure_requests = 0;
   int pressure_served = 0;
   int error_count = 0;
   int pixels_sent = 0;
   int results_seen = 0;
   int settings_count = 0;

   mandelbrot_escape_time_top #(
      .PIXEL_BITS (PIXEL_W),
      .FRAC_BITS  (FRAC_Q)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   function automatic longint clamp_coord(input longint v);
      if (v > COORD_MAX) begin
         return COORD_MAX;
      end else if (v < COORD_MIN) begin
         return COORD_MIN;
      end
      return v;
   endfunction

   // iterate z = z^2 + c from zero; >>> on longint floors like the hardware shift
   function automatic rsp_type predict_escape(input req_type px);
      longint cx, cy, x, y, x2, y2, nx, ny;
      int unsigned count, third;
      rsp_type r;
      cx = clamp_coord(longint'(cfg_origin_x) +
                       longint'(px.pixel_col) * longint'(cfg_step_x));
      cy = clamp_coord(longint'(cfg_origin_y) +
                       longint'(px.pixel_row) * longint'(cfg_step_y));
      x = 0;
      y = 0;
      count = 0;
      for (int unsigned i = 0; i < cfg_limit; i++) begin
         x2 = (x * x) >>> FRAC_Q;
         y2 = (y * y) >>> FRAC_Q;
         if (x2 + y2 > ESCAPE_RADIUS_SQ) break;
         count++;
         // 2xy as a shift by one bit less
         ny = ((x * y) >>> (FRAC_Q - 1)) + cy;
         nx = x2 - y2 + cx;
         x = clamp_coord(nx);
         y = clamp_coord(ny);
      end
      third = cfg_limit / 3;
      r.escape_count = COUNT_W'(count);
      if (count == cfg_limit) begin
         r.color_class = CLASS_BLACK;
      end else if (count < third) begin
         r.color_class = CLASS_WHITE;
      end else if (count < 2 * third) begin
         r.color_class = CLASS_GREEN;
      end else begin
         r.color_class = CLASS_BLUE;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // shared drivers
   // ---------------------------------------------------------------------

   // one pixel transfer; valid stays high for a back-to-back follower
   task automatic send_pixel(input int unsigned col, input int unsigned row);
      req_type px;
      int unsigned gap;
      px.pixel_col = PIXEL_W'(col);
      px.pixel_row = PIXEL_W'(row);
      gap = $urandom_range(0, tx_max_gap);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      // config is stable while pixels are in flight, so predict at acceptance
      pending_escapes.push_back(predict_escape(px));
      pixels_sent++;
   endtask

   // register write, mirrored into the predictor once the transfer happens
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ORIGIN_X: cfg_origin_x = value;
         CSR_ORIGIN_Y: cfg_origin_y = value;
         CSR_STEP_X:   cfg_step_x = value[STEP_W-1:0];
         CSR_STEP_Y:   cfg_step_y = value[STEP_W-1:0];
         CSR_MAX_ITER: cfg_limit = value[COUNT_W-1:0];
         default: ;   // unused indexes leave the registers alone
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_window(input logic [CSR_DATA_W-1:0] ox,
                                 input logic [CSR_DATA_W-1:0] oy,
                                 input logic [CSR_DATA_W-1:0] sx,
                                 input logic [CSR_DATA_W-1:0] sy,
                                 input logic [CSR_DATA_W-1:0] lim);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_STEP_X, sx);
      write_reg(CSR_STEP_Y, sy);
      write_reg(CSR_MAX_ITER, lim);
      settings_count++;
   endtask

   task automatic set_idling(input int unsigned tx, input int unsigned rx);
      tx_max_gap = tx;
      rsp_max_gap <= rx;
   endtask

   // drop valid, wait for every pending result, then let the engine settle
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (pending_escapes.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // result side: random stall per transfer, one long hold-off on request
   // ---------------------------------------------------------------------

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_escapes.size() == 0) begin
         $error("result with nothing pending: escape_count %0d color_class %0d",
                got.escape_count, got.color_class);
         error_count++;
      end else begin
         want = pending_escapes.pop_front();
         if (got.escape_count !== want.escape_count) begin
            $error("escape_count mismatch: expected %0d, actual %0d",
                   want.escape_count, got.escape_count);
            error_count++;
         end
         if (got.color_class !== want.color_class) begin
            $error("color_class mismatch: expected %0d, actual %0d",
                   want.color_class, got.color_class);
            error_count++;
         end
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
            rsp_hold = $urandom_range(0, rsp_max_gap);
         end
         // long hold-off lets the queue fill and back up into the input
         if (pressure_served != pressure_requests) begin
            pressure_served = pressure_requests;
            rsp_hold = PRESSURE_HOLD;
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset window and limit, corner pixels and alternating bit patterns
   task automatic test_reset_defaults();
      set_idling(8, 8);
      send_pixel(0, 0);
      send_pixel(PIXEL_MAX, PIXEL_MAX);
      send_pixel(PIXEL_MAX, 0);
      send_pixel(0, PIXEL_MAX);
      send_pixel(10'h2AA, 10'h155);
      send_pixel(10'h155, 10'h2AA);
      // c close to zero: never escapes, runs the full limit
      send_pixel(433, 325);
      finish_phase();
   endtask

   // limit of zero runs no iteration; upper data bits must be dropped
   task automatic test_zero_limit();
      write_reg(CSR_MAX_ITER, 32'hABCD_0000);
      settings_count++;
      send_pixel(0, 0);
      send_pixel(PIXEL_MAX, PIXEL_MAX);
      send_pixel(433, 325);
      finish_phase();
   endtask

   // limit of one: the first iteration from z = 0 always counts
   task automatic test_single_iteration();
      write_reg(CSR_MAX_ITER, 32'd1);
      settings_count++;
      send_pixel(PIXEL_MAX, PIXEL_MAX);
      finish_phase();
   endtask

   // c far above the coordinate range clamps at the upper end
   task automatic test_saturation();
      program_window(Q_MOST_POS, Q_MOST_NEG, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd3);
      send_pixel(PIXEL_MAX, 0);
      send_pixel(0, PIXEL_MAX);
      finish_phase();
   endtask

   // |z|^2 exactly four does not escape: c = -2 stays, c = +2 counts twice
   task automatic test_boundary_point();
      program_window(Q_MINUS_TWO, Q_ZERO, Q_TWO, Q_ZERO, 32'd200);
      send_pixel(0, 0);
      send_pixel(1, PIXEL_MAX);
      send_pixel(2, 0);
      send_pixel(3, 0);
      finish_phase();
   endtask

   // widest limit: one pixel inside the set, the rest escape early
   task automatic test_deep_limit();
      program_window(Q_ZERO, Q_ZERO, Q_ONE, Q_QUARTER, 32'(LIMIT_DEEP));
      send_pixel(0, 0);
      send_pixel(PIXEL_MAX, 0);
      send_pixel(0, 8);
      send_pixel(5, 5);
      finish_phase();
   endtask

   // writes to unused indexes must not disturb any register
   task automatic test_register_index_range();
      program_window(Q_MINUS_TWO, Q_MINUS_TWO, 32'd3145728, 32'd3145728, 32'd40);
      for (int i = CSR_UNUSED_FIRST; i <= CSR_UNUSED_LAST; i++) begin
         write_reg(CSR_INDEX_W'(i), $urandom());
      end
      send_pixel(400, 640);
      send_pixel(700, 500);
      finish_phase();
   endtask

   // default window at the default limit, random pixels
   task automatic test_default_window_random();
      set_idling(8, 8);
      program_window(ORIGIN_X_RESET, ORIGIN_Y_RESET, CSR_DATA_W'(STEP_X_RESET),
                     CSR_DATA_W'(STEP_Y_RESET), CSR_DATA_W'(MAX_ITER_RESET));
      repeat (100) send_pixel($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX));
      finish_phase();
   endtask

   // random views of the set with small limits, idling varied per window
   task automatic test_random_windows();
      logic [CSR_DATA_W-1:0] ox, oy, sx, sy;
      for (int w = 0; w < WINDOW_COUNT; w++) begin
         case (w % 4)
            0: set_idling(8, 8);
            1: set_idling(0, 0);
            2: set_idling(8, 0);
            default: set_idling(0, 8);
         endcase
         // origin between -2.5 and 0.5 real, -1.5 and 1.5 imaginary
         ox = 32'($urandom_range(0, 805306368)) - 32'd671088640;
         oy = 32'($urandom_range(0, 805306368)) - 32'd402653184;
         if ($urandom_range(0, 3) == 0) begin
            sx = $urandom();
            sy = $urandom();
         end else begin
            sx = $urandom_range(0, 1048576);
            sy = $urandom_range(0, 1048576);
         end
         program_window(ox, oy, sx, sy, $urandom_range(1, 48));
         repeat (WINDOW_ITEMS) begin
            send_pixel($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX));
         end
         finish_phase();
      end
   endtask

   // origin and step registers fully random, limit kept short so runs stay brief
   task automatic test_random_registers();
      set_idling(4, 4);
      program_window($urandom(), $urandom(), $urandom(), $urandom(),
                     ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 31));
      repeat (100) send_pixel($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX));
      finish_phase();
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      set_idling(0, 0);
      program_window(32'hF000_0000, 32'hF400_0000, 32'd1048576, 32'd786432, 32'd24);
      pressure_requests <= pressure_requests + 1;
      repeat (50) send_pixel($urandom_range(0, PIXEL_MAX), $urandom_range(0, PIXEL_MAX));
      finish_phase();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_limit();
      test_single_iteration();
      test_saturation();
      test_boundary_point();
      test_deep_limit();
      test_register_index_range();
      test_default_window_random();
      test_random_windows();
      test_random_registers();
      test_backpressure();
      $display("covered %0d pixels and %0d results across %0d register settings",
               pixels_sent, results_seen, settings_count);
      $display("limits from zero to the 16-bit maximum, with idling, back-to-back and hold-off");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // the slowest correct run is dominated by one full-limit pixel
   initial begin
      #15ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
